@@ sv/tdg_pkg.sv @@
package tdg_pkg;

   localparam int unsigned HAMMING_LIMIT = 0;

   // configuration register indexes
   localparam logic [2:0] CSR_KNOWN_TAGS     = 3'd0;
   localparam logic [2:0] CSR_MARGIN_FLOOR   = 3'd1;
   localparam logic [2:0] CSR_CONFIRM_NEEDED = 3'd2;
   localparam logic [2:0] CSR_CONFIRM_WINDOW = 3'd3;
   localparam logic [2:0] CSR_PUBLISH_GAP    = 3'd4;
   localparam logic [2:0] CSR_LOST_AFTER     = 3'd5;
   localparam logic [2:0] CSR_MAX_STEP_MM    = 3'd6;
   localparam logic [2:0] CSR_MAX_TURN       = 3'd7;

   // front classification of a beat
   localparam logic [2:0] KIND_NO_TAG  = 3'd0;
   localparam logic [2:0] KIND_MULTI   = 3'd1;
   localparam logic [2:0] KIND_UNKNOWN = 3'd2;
   localparam logic [2:0] KIND_HAMMING = 3'd3;
   localparam logic [2:0] KIND_MARGIN  = 3'd4;
   localparam logic [2:0] KIND_PASS    = 3'd5;
   localparam logic [2:0] KIND_TICK    = 3'd6;

   localparam logic [3:0] VERDICT_NO_TAG     = 4'd0;
   localparam logic [3:0] VERDICT_MULTI      = 4'd1;
   localparam logic [3:0] VERDICT_UNKNOWN    = 4'd2;
   localparam logic [3:0] VERDICT_HAMMING    = 4'd3;
   localparam logic [3:0] VERDICT_MARGIN     = 4'd4;
   localparam logic [3:0] VERDICT_CONFIRMING = 4'd5;
   localparam logic [3:0] VERDICT_JUMP       = 4'd6;
   localparam logic [3:0] VERDICT_RATE       = 4'd7;
   localparam logic [3:0] VERDICT_LOST       = 4'd8;
   localparam logic [3:0] VERDICT_ACCEPTED   = 4'd9;
   localparam logic [3:0] VERDICT_NONE       = 4'd10;

   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [31:0] known_tags;
      logic [15:0] margin_floor;
      logic [7:0]  confirm_needed;
      logic [31:0] confirm_window;
      logic [31:0] publish_gap;
      logic [31:0] lost_after;
      logic [15:0] max_step_mm;
      logic [15:0] max_turn;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [31:0]        now_ms;
      logic [9:0]         tag_id;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [15:0]        yaw;
   } item_type;

endpackage

@@ sv/tdg_front.sv @@
module tdg_front
   import tdg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic [31:0]        req_now_ms,
   input  logic [1:0]         req_detection_count,
   input  logic [9:0]         req_tag_id,
   input  logic [3:0]         req_hamming,
   input  logic [15:0]        req_margin,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [15:0]        req_yaw,
   output logic               push_valid,
   input  logic               push_ready,
   output item_type           push_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     known;
   logic [2:0] kind;

   assign known = (req_tag_id[9:5] == 5'd0) && cfg.known_tags[req_tag_id[4:0]];

   always_comb begin
      if (req_mode) begin
         kind = KIND_TICK;
      end else if (req_detection_count == 2'd0) begin
         kind = KIND_NO_TAG;
      end else if (req_detection_count != 2'd1) begin
         kind = KIND_MULTI;
      end else if (!known) begin
         kind = KIND_UNKNOWN;
      end else if (32'(req_hamming) > HAMMING_LIMIT) begin
         kind = KIND_HAMMING;
      end else if (req_margin < cfg.margin_floor) begin
         kind = KIND_MARGIN;
      end else begin
         kind = KIND_PASS;
      end
   end

   assign req_ready  = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      valid_in = valid_ff && !push_ready;
      item_in  = item_ff;
      if (req_valid && req_ready) begin
         valid_in       = 1'b1;
         item_in.kind   = kind;
         item_in.now_ms = req_now_ms;
         item_in.tag_id = req_tag_id;
         item_in.pos_x  = req_pos_x;
         item_in.pos_y  = req_pos_y;
         item_in.yaw    = req_yaw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

@@ sv/tdg_queue.sv @@
module tdg_queue
   import tdg_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type slot_ff [QUEUE_DEPTH];
   logic [$clog2(QUEUE_DEPTH)-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [$clog2(QUEUE_DEPTH)-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = count_ff != ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ sv/tdg_back.sv @@
module tdg_back
   import tdg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  item_type           pop_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_accepted,
   output logic [3:0]         rsp_verdict,
   output logic               rsp_has_detection,
   output logic [9:0]         rsp_out_tag_id,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic [15:0]        rsp_out_yaw
);

   // tracking state
   logic        seen_valid_ff, seen_valid_in;
   logic [31:0] seen_time_ff, seen_time_in;
   logic        kept_valid_ff, kept_valid_in;
   logic [9:0]  kept_tag_ff, kept_tag_in;
   logic [15:0] kept_x_ff, kept_x_in;
   logic [15:0] kept_y_ff, kept_y_in;
   logic [15:0] kept_yaw_ff, kept_yaw_in;
   logic        active_valid_ff, active_valid_in;
   logic [9:0]  active_tag_ff, active_tag_in;
   logic [7:0]  sightings_ff, sightings_in;
   logic        window_valid_ff, window_valid_in;
   logic [31:0] window_start_ff, window_start_in;
   logic        confirmed_ff, confirmed_in;
   logic        pub_valid_ff, pub_valid_in;
   logic [31:0] pub_time_ff, pub_time_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        accepted_ff, accepted_in;
   logic [3:0]  verdict_ff, verdict_in;
   logic        echo_ff, echo_in;
   logic [9:0]  tag_ff, tag_in;
   logic [15:0] x_ff, x_in;
   logic [15:0] y_ff, y_in;
   logic [15:0] yaw_ff, yaw_in;

   // squared step limit, follows max_step_mm through a register
   logic [31:0] lim2_ff, lim2_in;

   logic               take;
   logic [31:0]        now;
   logic               lost;
   logic signed [16:0] dx, dy;
   logic signed [33:0] dx2, dy2;
   logic [32:0]        dist2;
   logic [15:0]        dyaw;
   logic [16:0]        turn;
   logic               jump;
   logic               expired;
   logic               publish;

   assign take      = pop_valid && (!rsp_valid_ff || rsp_ready);
   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign now       = pop_item.now_ms;
   assign lost      = seen_valid_ff && ((now - seen_time_ff) > cfg.lost_after);
   assign lim2_in   = {16'd0, cfg.max_step_mm} * {16'd0, cfg.max_step_mm};

   assign dx    = $signed({pop_item.pos_x[15], pop_item.pos_x})
                - $signed({kept_x_ff[15], kept_x_ff});
   assign dy    = $signed({pop_item.pos_y[15], pop_item.pos_y})
                - $signed({kept_y_ff[15], kept_y_ff});
   assign dx2   = 34'(dx) * 34'(dx);
   assign dy2   = 34'(dy) * 34'(dy);
   assign dist2 = {1'b0, dx2[31:0]} + {1'b0, dy2[31:0]};
   assign dyaw  = pop_item.yaw - kept_yaw_ff;
   assign turn  = dyaw[15] ? (17'h10000 - {1'b0, dyaw}) : {1'b0, dyaw};
   // kept pose is forgotten first when the loss timeout has run out
   assign jump  = kept_valid_ff && !lost && (kept_tag_ff == pop_item.tag_id)
                  && ((dist2 > {1'b0, lim2_ff}) || (turn > {1'b0, cfg.max_turn}));

   always_comb begin
      seen_valid_in   = seen_valid_ff;
      seen_time_in    = seen_time_ff;
      kept_valid_in   = kept_valid_ff;
      kept_tag_in     = kept_tag_ff;
      kept_x_in       = kept_x_ff;
      kept_y_in       = kept_y_ff;
      kept_yaw_in     = kept_yaw_ff;
      active_valid_in = active_valid_ff;
      active_tag_in   = active_tag_ff;
      sightings_in    = sightings_ff;
      window_valid_in = window_valid_ff;
      window_start_in = window_start_ff;
      confirmed_in    = confirmed_ff;
      pub_valid_in    = pub_valid_ff;
      pub_time_in     = pub_time_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      accepted_in     = accepted_ff;
      verdict_in      = verdict_ff;
      echo_in         = echo_ff;
      tag_in          = tag_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      yaw_in          = yaw_ff;
      expired         = 1'b0;
      publish         = 1'b0;

      if (take) begin
         rsp_valid_in = 1'b1;
         accepted_in  = 1'b0;
         echo_in      = 1'b0;
         tag_in       = pop_item.tag_id;
         x_in         = pop_item.pos_x;
         y_in         = pop_item.pos_y;
         yaw_in       = pop_item.yaw;

         unique case (pop_item.kind) inside
            KIND_TICK: begin
               if (lost) begin
                  seen_valid_in   = 1'b0;
                  seen_time_in    = '0;
                  kept_valid_in   = 1'b0;
                  active_valid_in = 1'b0;
                  window_valid_in = 1'b0;
                  confirmed_in    = 1'b0;
                  verdict_in      = VERDICT_LOST;
               end else begin
                  verdict_in = VERDICT_NONE;
               end
            end
            KIND_NO_TAG, KIND_MULTI, KIND_UNKNOWN, KIND_HAMMING, KIND_MARGIN: begin
               active_valid_in = 1'b0;
               window_valid_in = 1'b0;
               confirmed_in    = 1'b0;
               case (pop_item.kind)
                  KIND_NO_TAG:  verdict_in = VERDICT_NO_TAG;
                  KIND_MULTI:   verdict_in = VERDICT_MULTI;
                  KIND_UNKNOWN: verdict_in = VERDICT_UNKNOWN;
                  KIND_HAMMING: verdict_in = VERDICT_HAMMING;
                  default:      verdict_in = VERDICT_MARGIN;
               endcase
            end
            KIND_PASS: begin
               if (lost) begin
                  kept_valid_in   = 1'b0;
                  active_valid_in = 1'b0;
                  window_valid_in = 1'b0;
                  confirmed_in    = 1'b0;
               end
               seen_valid_in = 1'b1;
               seen_time_in  = now;
               if (jump) begin
                  active_valid_in = 1'b0;
                  window_valid_in = 1'b0;
                  confirmed_in    = 1'b0;
                  verdict_in      = VERDICT_JUMP;
               end else begin
                  // confirmed on another tag: start over
                  if (confirmed_in
                      && (!active_valid_in || active_tag_in != pop_item.tag_id)) begin
                     active_valid_in = 1'b0;
                     window_valid_in = 1'b0;
                     confirmed_in    = 1'b0;
                  end
                  publish = confirmed_in;
                  if (!confirmed_in) begin
                     expired = !window_valid_in
                               || ((now - window_start_in) > cfg.confirm_window);
                     if (!active_valid_in || active_tag_in != pop_item.tag_id
                         || expired) begin
                        active_valid_in = 1'b1;
                        active_tag_in   = pop_item.tag_id;
                        sightings_in    = 8'd1;
                        window_valid_in = 1'b1;
                        window_start_in = now;
                     end else if (sightings_in != 8'hFF) begin
                        sightings_in = sightings_in + 8'd1;
                     end
                     if (sightings_in < cfg.confirm_needed) begin
                        verdict_in = VERDICT_CONFIRMING;
                        echo_in    = 1'b1;
                     end else begin
                        confirmed_in = 1'b1;
                        publish      = 1'b1;
                     end
                  end
                  if (publish) begin
                     echo_in = 1'b1;
                     if (pub_valid_ff && ((now - pub_time_ff) < cfg.publish_gap)) begin
                        verdict_in = VERDICT_RATE;
                     end else begin
                        kept_valid_in = 1'b1;
                        kept_tag_in   = pop_item.tag_id;
                        kept_x_in     = pop_item.pos_x;
                        kept_y_in     = pop_item.pos_y;
                        kept_yaw_in   = pop_item.yaw;
                        pub_valid_in  = 1'b1;
                        pub_time_in   = now;
                        verdict_in    = VERDICT_ACCEPTED;
                        accepted_in   = 1'b1;
                     end
                  end
               end
            end
            default: begin
               verdict_in = VERDICT_NONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_valid_ff   <= 1'b0;
         seen_time_ff    <= '0;
         kept_valid_ff   <= 1'b0;
         active_valid_ff <= 1'b0;
         window_valid_ff <= 1'b0;
         confirmed_ff    <= 1'b0;
         pub_valid_ff    <= 1'b0;
         pub_time_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         seen_valid_ff   <= seen_valid_in;
         seen_time_ff    <= seen_time_in;
         kept_valid_ff   <= kept_valid_in;
         active_valid_ff <= active_valid_in;
         window_valid_ff <= window_valid_in;
         confirmed_ff    <= confirmed_in;
         pub_valid_ff    <= pub_valid_in;
         pub_time_ff     <= pub_time_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      kept_tag_ff     <= kept_tag_in;
      kept_x_ff       <= kept_x_in;
      kept_y_ff       <= kept_y_in;
      kept_yaw_ff     <= kept_yaw_in;
      active_tag_ff   <= active_tag_in;
      sightings_ff    <= sightings_in;
      window_start_ff <= window_start_in;
      accepted_ff     <= accepted_in;
      verdict_ff      <= verdict_in;
      echo_ff         <= echo_in;
      tag_ff          <= tag_in;
      x_ff            <= x_in;
      y_ff            <= y_in;
      yaw_ff          <= yaw_in;
      lim2_ff         <= lim2_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = accepted_ff;
   assign rsp_verdict       = verdict_ff;
   assign rsp_has_detection = echo_ff;
   assign rsp_out_tag_id    = echo_ff ? tag_ff : '0;
   assign rsp_out_x         = echo_ff ? x_ff : '0;
   assign rsp_out_y         = echo_ff ? y_ff : '0;
   assign rsp_out_yaw       = echo_ff ? yaw_ff : '0;

endmodule

@@ sv/tag_detection_gate.sv @@
// Fiducial-tag detection gate.
// req_ channel: one beat per camera frame (req_mode 0) or per loss-check tick
// (req_mode 1). The front stage classifies the frame (no tag, several tags,
// unknown id, bit errors, low margin) and passes it through a two-entry queue
// to the back stage, which owns the loss timeout, jump test, confirmation
// window and publication rate limit.
// rsp_ channel: exactly one beat per request, in order. A request passes through
// the front register, a queue slot and the result register; one request and one
// result per cycle are sustained while rsp_ready stays high. The back stage
// updates its state combinationally (two 17x17 squares, add and compare
// against the registered squared limit), which lets it keep that rate.
// csr_ channel: csr_index selects one of eight registers, always ready; write
// only while no request is in flight.
// Reset (synchronous, active high) loads the register defaults and clears all
// tracking valid flags and the queue. When rsp_ready is low the result register
// holds, the queue fills, and req_ready drops once front and queue are full.
module tag_detection_gate
   import tdg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic [31:0]        req_now_ms,
   input  logic [1:0]         req_detection_count,
   input  logic [9:0]         req_tag_id,
   input  logic [3:0]         req_hamming,
   input  logic [15:0]        req_margin,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [15:0]        req_yaw,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_accepted,
   output logic [3:0]         rsp_verdict,
   output logic               rsp_has_detection,
   output logic [9:0]         rsp_out_tag_id,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic [15:0]        rsp_out_yaw
);

   cfg_type  cfg_ff, cfg_in;
   logic     push_valid, push_ready;
   item_type push_item;
   logic     pop_valid, pop_ready;
   item_type pop_item;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_KNOWN_TAGS:     cfg_in.known_tags     = csr_wdata;
            CSR_MARGIN_FLOOR:   cfg_in.margin_floor   = csr_wdata[15:0];
            CSR_CONFIRM_NEEDED: cfg_in.confirm_needed = csr_wdata[7:0];
            CSR_CONFIRM_WINDOW: cfg_in.confirm_window = csr_wdata;
            CSR_PUBLISH_GAP:    cfg_in.publish_gap    = csr_wdata;
            CSR_LOST_AFTER:     cfg_in.lost_after     = csr_wdata;
            CSR_MAX_STEP_MM:    cfg_in.max_step_mm    = csr_wdata[15:0];
            CSR_MAX_TURN:       cfg_in.max_turn       = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.known_tags     <= 32'd1;
         cfg_ff.margin_floor   <= 16'd320;
         cfg_ff.confirm_needed <= 8'd3;
         cfg_ff.confirm_window <= 32'd500;
         cfg_ff.publish_gap    <= 32'd100;
         cfg_ff.lost_after     <= 32'd1000;
         cfg_ff.max_step_mm    <= 16'd200;
         cfg_ff.max_turn       <= 16'd2731;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tdg_front u_front (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_now_ms          (req_now_ms),
      .req_detection_count (req_detection_count),
      .req_tag_id          (req_tag_id),
      .req_hamming         (req_hamming),
      .req_margin          (req_margin),
      .req_pos_x           (req_pos_x),
      .req_pos_y           (req_pos_y),
      .req_yaw             (req_yaw),
      .push_valid          (push_valid),
      .push_ready          (push_ready),
      .push_item           (push_item)
   );

   tdg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   tdg_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_item          (pop_item),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_accepted      (rsp_accepted),
      .rsp_verdict       (rsp_verdict),
      .rsp_has_detection (rsp_has_detection),
      .rsp_out_tag_id    (rsp_out_tag_id),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_out_yaw       (rsp_out_yaw)
   );

`ifndef SYNTH
   // echoed pose only on confirming, rate-limited and published beats
   a_echo_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_detection |->
         (rsp_verdict == VERDICT_CONFIRMING || rsp_verdict == VERDICT_RATE ||
          rsp_verdict == VERDICT_ACCEPTED))
      else $error("echo on a verdict that carries no detection");

   a_accept_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |->
         (rsp_has_detection && rsp_verdict == VERDICT_ACCEPTED))
      else $error("published beat without echo or accepted verdict");

   // a full queue must present data to the back stage
   a_queue_full: assert property (@(posedge clock) disable iff (reset)
      !push_ready |-> pop_valid)
      else $error("queue full but empty");
`endif

endmodule

@@ tb/sv/verdict_checker.sv @@
module verdict_checker
   import tdg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_mode,
   input  logic [31:0]        req_now_ms,
   input  logic [1:0]         req_detection_count,
   input  logic [9:0]         req_tag_id,
   input  logic [3:0]         req_hamming,
   input  logic [15:0]        req_margin,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [15:0]        req_yaw,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_accepted,
   input  logic [3:0]         rsp_verdict,
   input  logic               rsp_has_detection,
   input  logic [9:0]         rsp_out_tag_id,
   input  logic signed [15:0] rsp_out_x,
   input  logic signed [15:0] rsp_out_y,
   input  logic [15:0]        rsp_out_yaw,
   output int                 errors,
   output int                 pending
);

   typedef struct packed {
      logic        accepted;
      logic [3:0]  verdict;
      logic        has_detection;
      logic [9:0]  tag_id;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] yaw;
   } outcome_type;

   cfg_type     cfg;

   logic        seen_valid;
   logic [31:0] seen_time;
   logic        kept_valid;
   logic [9:0]  kept_tag;
   logic [15:0] kept_x, kept_y, kept_yaw;
   logic        active_valid;
   logic [9:0]  active_tag;
   logic [7:0]  sightings;
   logic        window_valid;
   logic [31:0] window_start;
   logic        is_confirmed;
   logic        pub_valid;
   logic [31:0] pub_time;

   outcome_type verdicts_due[$];
   int          miss_count = 0;
   int          due_count = 0;

   assign errors  = miss_count;
   assign pending = due_count;

   task automatic flag(string what);
      miss_count++;
      $display("%0t: mismatch: %s", $time, what);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         flag($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
      end
   endtask

   function automatic void drop_confirmation();
      active_valid = 1'b0;
      active_tag   = '0;
      sightings    = '0;
      window_valid = 1'b0;
      window_start = '0;
      is_confirmed = 1'b0;
   endfunction

   function automatic void forget_pose();
      kept_valid = 1'b0;
      kept_tag   = '0;
      kept_x     = '0;
      kept_y     = '0;
      kept_yaw   = '0;
   endfunction

   // position compared squared; yaw by the shorter way round the circle
   function automatic logic pose_jumped(logic [9:0] tag, logic signed [15:0] x,
                                        logic signed [15:0] y, logic [15:0] yaw);
      longint      dx, dy, lim;
      logic [15:0] d;
      int unsigned turn;
      if (!kept_valid || kept_tag != tag) begin
         return 1'b0;
      end
      dx   = longint'(x) - longint'($signed(kept_x));
      dy   = longint'(y) - longint'($signed(kept_y));
      lim  = longint'(cfg.max_step_mm) * longint'(cfg.max_step_mm);
      d    = yaw - kept_yaw;
      turn = d[15] ? 32'h10000 - d : d;
      return (dx * dx + dy * dy > lim) || (turn > cfg.max_turn);
   endfunction

   function automatic outcome_type grade_beat(logic mode, logic [31:0] now,
                                              logic [1:0] count,
                                              logic [9:0] tag, logic [3:0] ham,
                                              logic [15:0] marg, logic signed [15:0] x,
                                              logic signed [15:0] y, logic [15:0] yaw);
      outcome_type o;
      logic [3:0]  v;
      logic        echo;
      logic        to_publish;
      o          = '0;
      v          = VERDICT_NONE;
      echo       = 1'b0;
      to_publish = 1'b0;
      if (mode) begin
         if (seen_valid && now - seen_time > cfg.lost_after) begin
            seen_valid = 1'b0;
            seen_time  = '0;
            forget_pose();
            drop_confirmation();
            v = VERDICT_LOST;
         end
      end else if (count == 2'd0) begin
         v = VERDICT_NO_TAG;
      end else if (count != 2'd1) begin
         v = VERDICT_MULTI;
      end else if (tag >= 10'd32 || !cfg.known_tags[tag[4:0]]) begin
         v = VERDICT_UNKNOWN;
      end else if (ham > HAMMING_LIMIT) begin
         v = VERDICT_HAMMING;
      end else if (marg < cfg.margin_floor) begin
         v = VERDICT_MARGIN;
      end else begin
         if (seen_valid && now - seen_time > cfg.lost_after) begin
            forget_pose();
            drop_confirmation();
         end
         seen_valid = 1'b1;
         seen_time  = now;
         if (pose_jumped(tag, x, y, yaw)) begin
            v = VERDICT_JUMP;
         end else begin
            to_publish = 1'b1;
            if (is_confirmed && (!active_valid || active_tag != tag)) begin
               drop_confirmation();
            end
            if (!is_confirmed) begin
               if (!active_valid || active_tag != tag || !window_valid ||
                   now - window_start > cfg.confirm_window) begin
                  active_valid = 1'b1;
                  active_tag   = tag;
                  sightings    = 8'd1;
                  window_valid = 1'b1;
                  window_start = now;
               end else if (sightings != 8'hFF) begin
                  sightings++;
               end
               if (sightings < cfg.confirm_needed) begin
                  v          = VERDICT_CONFIRMING;
                  echo       = 1'b1;
                  to_publish = 1'b0;
               end else begin
                  is_confirmed = 1'b1;
               end
            end
            if (to_publish) begin
               echo = 1'b1;
               if (pub_valid && now - pub_time < cfg.publish_gap) begin
                  v = VERDICT_RATE;
               end else begin
                  kept_valid = 1'b1;
                  kept_tag   = tag;
                  kept_x     = x;
                  kept_y     = y;
                  kept_yaw   = yaw;
                  pub_valid  = 1'b1;
                  pub_time   = now;
                  v          = VERDICT_ACCEPTED;
                  o.accepted = 1'b1;
               end
            end
         end
      end
      // every reject clears the confirmation, except a rate-limited one
      if (v <= VERDICT_MARGIN || v == VERDICT_JUMP) begin
         drop_confirmation();
      end
      o.verdict       = v;
      o.has_detection = echo;
      if (echo) begin
         o.tag_id = tag;
         o.x      = x;
         o.y      = y;
         o.yaw    = yaw;
      end
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type due;
      if (reset) begin
         cfg = '{32'd1, 16'd320, 8'd3, 32'd500, 32'd100, 32'd1000, 16'd200, 16'd2731};
         seen_valid = 1'b0;
         seen_time  = '0;
         pub_valid  = 1'b0;
         pub_time   = '0;
         forget_pose();
         drop_confirmation();
         verdicts_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               flag("result beat with nothing outstanding");
            end else begin
               due = verdicts_due.pop_front();
               check_field("accepted", 32'(rsp_accepted), 32'(due.accepted));
               check_field("verdict", 32'(rsp_verdict), 32'(due.verdict));
               check_field("has_detection", 32'(rsp_has_detection),
                           32'(due.has_detection));
               check_field("out_tag_id", 32'(rsp_out_tag_id), 32'(due.tag_id));
               check_field("out_x", 32'($unsigned(rsp_out_x)), 32'(due.x));
               check_field("out_y", 32'($unsigned(rsp_out_y)), 32'(due.y));
               check_field("out_yaw", 32'(rsp_out_yaw), 32'(due.yaw));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KNOWN_TAGS:     cfg.known_tags     = csr_wdata;
               CSR_MARGIN_FLOOR:   cfg.margin_floor   = csr_wdata[15:0];
               CSR_CONFIRM_NEEDED: cfg.confirm_needed = csr_wdata[7:0];
               CSR_CONFIRM_WINDOW: cfg.confirm_window = csr_wdata;
               CSR_PUBLISH_GAP:    cfg.publish_gap    = csr_wdata;
               CSR_LOST_AFTER:     cfg.lost_after     = csr_wdata;
               CSR_MAX_STEP_MM:    cfg.max_step_mm    = csr_wdata[15:0];
               CSR_MAX_TURN:       cfg.max_turn       = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            verdicts_due.push_back(grade_beat(req_mode, req_now_ms, req_detection_count,
                                              req_tag_id, req_hamming, req_margin,
                                              req_pos_x, req_pos_y, req_yaw));
         end
      end
      due_count = verdicts_due.size();
   end

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top
   import tdg_pkg::*;
();

   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 28;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_mode = 1'b0;
   logic [31:0]        req_now_ms = '0;
   logic [1:0]         req_detection_count = '0;
   logic [9:0]         req_tag_id = '0;
   logic [3:0]         req_hamming = '0;
   logic [15:0]        req_margin = '0;
   logic signed [15:0] req_pos_x = '0;
   logic signed [15:0] req_pos_y = '0;
   logic [15:0]        req_yaw = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_accepted;
   logic [3:0]         rsp_verdict;
   logic               rsp_has_detection;
   logic [9:0]         rsp_out_tag_id;
   logic signed [15:0] rsp_out_x;
   logic signed [15:0] rsp_out_y;
   logic [15:0]        rsp_out_yaw;

   int          errors;
   int          pending;
   int          cycles = 0;
   logic        calm = 1'b0;

   // stimulus-side view of the block's settings and the tracked target
   cfg_type     settings;
   int          noise_pct;
   logic [31:0] wall_ms;
   logic [9:0]  session_tag;
   logic [15:0] cur_x, cur_y, cur_yaw;

   tag_detection_gate i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_now_ms          (req_now_ms),
      .req_detection_count (req_detection_count),
      .req_tag_id          (req_tag_id),
      .req_hamming         (req_hamming),
      .req_margin          (req_margin),
      .req_pos_x           (req_pos_x),
      .req_pos_y           (req_pos_y),
      .req_yaw             (req_yaw),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_accepted        (rsp_accepted),
      .rsp_verdict         (rsp_verdict),
      .rsp_has_detection   (rsp_has_detection),
      .rsp_out_tag_id      (rsp_out_tag_id),
      .rsp_out_x           (rsp_out_x),
      .rsp_out_y           (rsp_out_y),
      .rsp_out_yaw         (rsp_out_yaw)
   );

   verdict_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_now_ms          (req_now_ms),
      .req_detection_count (req_detection_count),
      .req_tag_id          (req_tag_id),
      .req_hamming         (req_hamming),
      .req_margin          (req_margin),
      .req_pos_x           (req_pos_x),
      .req_pos_y           (req_pos_y),
      .req_yaw             (req_yaw),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_accepted        (rsp_accepted),
      .rsp_verdict         (rsp_verdict),
      .rsp_has_detection   (rsp_has_detection),
      .rsp_out_tag_id      (rsp_out_tag_id),
      .rsp_out_x           (rsp_out_x),
      .rsp_out_y           (rsp_out_y),
      .rsp_out_yaw         (rsp_out_yaw),
      .errors              (errors),
      .pending             (pending)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      rsp_ready <= calm || $urandom_range(99) >= IDLE_PCT;
   end

   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("tb_top: FAIL");
      $finish;
   end

   // valid stays up across back-to-back beats; it only drops for an idle gap or in settle
   task automatic send(input logic mode, input logic [31:0] now, input logic [1:0] count,
                       input logic [9:0] tag, input logic [3:0] ham, input logic [15:0] marg,
                       input logic [15:0] x, input logic [15:0] y, input logic [15:0] yaw);
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IDLE_PCT);
      end
      req_valid           <= 1'b1;
      req_mode            <= mode;
      req_now_ms          <= now;
      req_detection_count <= count;
      req_tag_id          <= tag;
      req_hamming         <= ham;
      req_margin          <= marg;
      req_pos_x           <= x;
      req_pos_y           <= y;
      req_yaw             <= yaw;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold off until every outstanding result beat has come back
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   task automatic apply_settings(input cfg_type c);
      for (int i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= 3'(i);
         case (3'(i))
            CSR_KNOWN_TAGS:     csr_wdata <= c.known_tags;
            CSR_MARGIN_FLOOR:   csr_wdata <= {16'd0, c.margin_floor};
            CSR_CONFIRM_NEEDED: csr_wdata <= {24'd0, c.confirm_needed};
            CSR_CONFIRM_WINDOW: csr_wdata <= c.confirm_window;
            CSR_PUBLISH_GAP:    csr_wdata <= c.publish_gap;
            CSR_LOST_AFTER:     csr_wdata <= c.lost_after;
            CSR_MAX_STEP_MM:    csr_wdata <= {16'd0, c.max_step_mm};
            CSR_MAX_TURN:       csr_wdata <= {16'd0, c.max_turn};
            default:            csr_wdata <= '0;
         endcase
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      settings = c;
   endtask

   function automatic logic [9:0] pick_tag();
      logic [4:0] id;
      for (int n = 0; n < 64; n++) begin
         id = 5'($urandom);
         if (settings.known_tags[id]) begin
            return {5'd0, id};
         end
      end
      return 10'($urandom_range(31));
   endfunction

   task automatic random_beat();
      int          r;
      logic [3:0]  ham;
      logic [15:0] marg;
      r = $urandom_range(99);
      if (r < 70) begin
         wall_ms += $urandom_range(60);
      end else if (r < 90) begin
         wall_ms += $urandom_range(700);
      end else if (r < 98) begin
         wall_ms += $urandom_range(3000);
      end else begin
         wall_ms += $urandom;
      end
      r = $urandom_range(99);
      if (r < noise_pct / 3) begin
         send(1'b1, wall_ms, 2'($urandom), 10'($urandom), 4'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom));
      end else if (r < noise_pct) begin
         send(1'b0, wall_ms, 2'($urandom), 10'($urandom), 4'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
         if ($urandom_range(99) < noise_pct / 5) begin
            session_tag = pick_tag();
         end
         r = $urandom_range(99);
         if (r >= 30 && r < 95) begin
            cur_x   = cur_x + 16'($urandom_range(20)) - 16'd10;
            cur_y   = cur_y + 16'($urandom_range(20)) - 16'd10;
            cur_yaw = cur_yaw + 16'($urandom_range(4000)) - 16'd2000;
         end else if (r >= 95) begin
            cur_x   = 16'($urandom);
            cur_y   = 16'($urandom);
            cur_yaw = 16'($urandom);
         end
         ham  = $urandom_range(99) < 97 ? 4'd0 : 4'($urandom);
         marg = $urandom_range(99) < 97 ?
                16'(settings.margin_floor + $urandom_range(65535 - settings.margin_floor)) :
                16'($urandom);
         send(1'b0, wall_ms, 2'd1, session_tag, ham, marg, cur_x, cur_y, cur_yaw);
      end
      if ($urandom_range(99) == 0) begin
         settle();
      end
   endtask

   task automatic run_phase(input cfg_type c, input int items, input int noise);
      settle();
      apply_settings(c);
      noise_pct   = noise;
      wall_ms     = $urandom;
      session_tag = pick_tag();
      repeat (items) random_beat();
   endtask

   initial begin
      cfg_type c;
      settings = '{32'd1, 16'd320, 8'd3, 32'd500, 32'd100, 32'd1000, 16'd200, 16'd2731};
      cur_x    = '0;
      cur_y    = '0;
      cur_yaw  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: only tag 0 known
      send(1'b1, 32'd0, 2'd0, 10'd0, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send(1'b0, 32'd10, 2'd0, 10'd0, 4'd0, 16'd400, 16'd0, 16'd0, 16'd0);
      send(1'b0, 32'd10, 2'd2, 10'd0, 4'd0, 16'd400, 16'd0, 16'd0, 16'd0);
      send(1'b0, 32'd10, 2'd3, 10'd0, 4'd0, 16'd400, 16'd0, 16'd0, 16'd0);
      send(1'b0, 32'd10, 2'd1, 10'd1, 4'd0, 16'd400, 16'd0, 16'd0, 16'd0);
      send(1'b0, 32'd10, 2'd1, 10'h3FF, 4'd0, 16'd400, 16'd0, 16'd0, 16'd0);
      send(1'b0, 32'd10, 2'd1, 10'd32, 4'd0, 16'd400, 16'd0, 16'd0, 16'd0);
      send(1'b0, 32'd10, 2'd1, 10'd0, 4'd1, 16'd400, 16'd0, 16'd0, 16'd0);
      send(1'b0, 32'd10, 2'd1, 10'd0, 4'hF, 16'd400, 16'd0, 16'd0, 16'd0);
      send(1'b0, 32'd10, 2'd1, 10'd0, 4'd0, 16'd319, 16'd0, 16'd0, 16'd0);
      send(1'b0, 32'd10, 2'd1, 10'd0, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      // confirm over three sightings, then rate limit
      send(1'b0, 32'd1000, 2'd1, 10'd0, 4'd0, 16'd320, 16'd100, -16'sd100, 16'd0);
      send(1'b0, 32'd1010, 2'd1, 10'd0, 4'd0, 16'd320, 16'd100, -16'sd100, 16'd0);
      send(1'b0, 32'd1020, 2'd1, 10'd0, 4'd0, 16'd320, 16'd100, -16'sd100, 16'd0);
      send(1'b0, 32'd1030, 2'd1, 10'd0, 4'd0, 16'd320, 16'd100, -16'sd100, 16'd0);
      // position step of 201 mm, then yaw just over and exactly at the limit
      send(1'b0, 32'd1200, 2'd1, 10'd0, 4'd0, 16'd320, 16'd301, -16'sd100, 16'd0);
      send(1'b0, 32'd1300, 2'd1, 10'd0, 4'd0, 16'd320, 16'd100, -16'sd100, 16'd2732);
      send(1'b0, 32'd1310, 2'd1, 10'd0, 4'd0, 16'd320, 16'd100, -16'sd100, 16'd62805);
      // loss tick just past the timeout, then again with nothing seen
      send(1'b1, 32'd2311, 2'd1, 10'd0, 4'd0, 16'd320, 16'd0, 16'd0, 16'd0);
      send(1'b1, 32'd2400, 2'd1, 10'd0, 4'd0, 16'd320, 16'd0, 16'd0, 16'd0);
      // extreme pose across the time wrap, then the largest possible step
      send(1'b0, 32'hFFFF_FFF0, 2'd1, 10'd0, 4'd0, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF);
      send(1'b0, 32'd5, 2'd1, 10'd0, 4'd0, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF);
      send(1'b0, 32'd20, 2'd1, 10'd0, 4'd0, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF);
      send(1'b0, 32'd20, 2'd1, 10'd0, 4'd0, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF);
      // tick exactly at the timeout is not a loss
      send(1'b1, 32'd1020, 2'd0, 10'd0, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0);

      noise_pct   = 25;
      wall_ms     = 32'd3000;
      session_tag = 10'd0;
      repeat (300) random_beat();

      // upper extremes
      run_phase('{32'hFFFF_FFFF, 16'd0, 8'd1, 32'd1, 32'd0, 32'd1, 16'hFFFF, 16'd32768},
                300, 25);

      // long confirmation, clean sightings, no idling on either side
      calm = 1'b1;
      run_phase('{32'h8000_0001, 16'hFFFF, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 16'd1, 16'd1}, 350, 0);
      settle();
      calm = 1'b0;

      // zero settings
      c = '{32'($urandom) | 32'd1, 16'($urandom_range(400)), 8'd0, 32'd0, 32'd0, 32'd0,
            16'd0, 16'd0};
      run_phase(c, 300, 20);

      repeat (2) begin
         c.known_tags     = 32'($urandom) | 32'd1;
         c.margin_floor   = 16'($urandom_range(1000));
         c.confirm_needed = 8'($urandom_range(1, 6));
         c.confirm_window = $urandom_range(50, 1000);
         c.publish_gap    = $urandom_range(200);
         c.lost_after     = $urandom_range(100, 3000);
         c.max_step_mm    = 16'($urandom_range(1, 300));
         c.max_turn       = 16'($urandom_range(1, 8000));
         run_phase(c, 350, 20);
      end

      settle();
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (errors == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/tdg_pkg.sv
sv/tdg_front.sv
sv/tdg_queue.sv
sv/tdg_back.sv
sv/tag_detection_gate.sv
tb/sv/verdict_checker.sv
tb/sv/tb_top.sv
